>>> sv/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/vf4_pkg.sv
`timescale 1ns / 1ps

package vf4_pkg;

    // Payload widths.
    localparam int PIXEL_W = 8;
    localparam int PROD_W  = 2 * PIXEL_W;
    localparam int DIFF_W  = PROD_W + 1;
    localparam int SCORE_W = 48;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_WIDTH_W  = 6;
    localparam int CFG_HEIGHT_W = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

    localparam logic [CFG_WIDTH_W-1:0]  CFG_WIDTH_RESET  = 6'd16;
    localparam logic [CFG_HEIGHT_W-1:0] CFG_HEIGHT_RESET = 10'd480;

    typedef logic [PIXEL_W-1:0]        t_pixel;
    typedef logic [PROD_W-1:0]         t_prod;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [SCORE_W-1:0] t_score;

endpackage

>>> sv/vf4_line_store.sv
`timescale 1ns / 1ps

module vf4_line_store #(
    parameter int MAX_WIDTH = 32,
    parameter int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  vf4_pkg::t_pixel i_wr_pixel,
    output vf4_pkg::t_pixel o_above1,
    output vf4_pkg::t_pixel o_above2
);
    import vf4_pkg::*;

    t_pixel r_mem1 [MAX_WIDTH];
    t_pixel r_mem2 [MAX_WIDTH];
    t_pixel r_rd1;
    t_pixel r_rd2;

    // The row above shifts down into the store two rows above as the new pixel lands.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem1[i_wr_addr] <= i_wr_pixel;
            r_mem2[i_wr_addr] <= r_rd1;
        end
    end

    // Registered read; a write to the same column in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd1 <= i_wr_pixel;
                r_rd2 <= r_rd1;
            end else begin
                r_rd1 <= r_mem1[i_rd_addr];
                r_rd2 <= r_mem2[i_rd_addr];
            end
        end
    end

    assign o_above1 = r_rd1;
    assign o_above2 = r_rd2;

endmodule

>>> sv/vollath_f4_focus_measure.sv
// Vollath F4 focus measure over a raster-order pixel stream.
// Throughput: one pixel per clock while o_stall is low; the line stores take one read and one write per cycle.
// Path: the last pixel of a window passes stage A and stage B, and its score lands in the result register.
// Reset (synchronous, active low) clears counters, sums and valids and loads
// width 16 and height 480; the line stores keep their contents.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vollath_f4_focus_measure #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Pixel input channel.
    input  logic                               i_valid,
    output logic                               o_stall,
    input  vf4_pkg::t_pixel                    i_pixel,
    // Score output channel.
    output logic                               o_valid,
    input  logic                               i_stall,
    output vf4_pkg::t_score                    o_focus_score,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vf4_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [vf4_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import vf4_pkg::*;

    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int RCW = $clog2(MAX_HEIGHT + 1);

    // Configuration registers.
    logic [CFG_WIDTH_W-1:0]  r_cfg_width;
    logic [CFG_HEIGHT_W-1:0] r_cfg_height;
    logic                    cfg_write;
    logic                    cfg_restart;

    // Window position of the next pixel.
    logic [WCW-1:0] r_col;
    logic [RCW-1:0] r_row;
    logic [WCW-1:0] width_last;
    logic [RCW-1:0] height_last;
    logic           col_last;
    logic           row_last;

    // Pipeline control.
    logic adv;
    logic accept;

    // Stage A: accepted pixel waiting for its line store reads.
    logic           r_a_valid;
    t_pixel         r_a_pixel;
    logic [AW-1:0]  r_a_col;
    logic           r_a_lag1;
    logic           r_a_lag2;
    logic           r_a_last;
    t_pixel         above1;
    t_pixel         above2;
    t_prod          prod1;
    t_prod          prod2;

    // Stage B: product difference.
    logic           r_b_valid;
    logic           r_b_last;
    t_diff          r_b_diff;

    // Accumulator and result register.
    t_score         r_sum;
    t_score         n_sum;
    logic           r_out_valid;
    t_score         r_out_score;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign cfg_restart = cfg_write && (i_cfg_index inside {CFG_IDX_WIDTH, CFG_IDX_HEIGHT});

    // Configuration writes; a write to either register restarts the window,
    // and a write to any other index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_WIDTH_RESET;
            r_cfg_height <= CFG_HEIGHT_RESET;
        end else if (cfg_write) begin
            case (i_cfg_index)
                CFG_IDX_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                CFG_IDX_HEIGHT: r_cfg_height <= i_cfg_data[CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero counts as one and anything above the bound saturates to it.
    always_comb begin
        if (r_cfg_width == '0) begin
            width_last = '0;
        end else if (int'(r_cfg_width) > MAX_WIDTH) begin
            width_last = WCW'(MAX_WIDTH - 1);
        end else begin
            width_last = WCW'(int'(r_cfg_width) - 1);
        end
        if (r_cfg_height == '0) begin
            height_last = '0;
        end else if (int'(r_cfg_height) > MAX_HEIGHT) begin
            height_last = RCW'(MAX_HEIGHT - 1);
        end else begin
            height_last = RCW'(int'(r_cfg_height) - 1);
        end
    end

    assign col_last = (r_col == width_last);
    assign row_last = (r_row == height_last);

    // The pipeline holds only when a finished score waits and another is about to land.
    assign adv     = !(r_out_valid && i_stall && r_b_valid && r_b_last);
    assign o_stall = !adv;
    assign accept  = i_valid && adv;

    // Column and row counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Stage A register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pixel <= i_pixel;
            r_a_col   <= r_col[AW-1:0];
            r_a_lag1  <= (r_row != '0);
            r_a_lag2  <= (r_row > RCW'(1));
            r_a_last  <= col_last && row_last;
        end
    end

    // Line stores for the two previous rows.
    vf4_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_line_store (
        .i_clk      (i_clk),
        .i_rd_en    (accept),
        .i_rd_addr  (r_col[AW-1:0]),
        .i_wr_en    (adv && r_a_valid),
        .i_wr_addr  (r_a_col),
        .i_wr_pixel (r_a_pixel),
        .o_above1   (above1),
        .o_above2   (above2)
    );

    // Both lag products, masked by row; the operands are widened before the multiply.
    always_comb begin
        prod1 = r_a_lag1 ? t_prod'(r_a_pixel) * t_prod'(above1) : '0;
        prod2 = r_a_lag2 ? t_prod'(r_a_pixel) * t_prod'(above2) : '0;
    end

    // Stage B register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_a_valid) begin
            r_b_last <= r_a_last;
            r_b_diff <= t_diff'({1'b0, prod1}) - t_diff'({1'b0, prod2});
        end
    end

    // One accumulator holds the difference of the two lag sums.
    assign n_sum = r_sum + t_score'(r_b_diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart) begin
            r_sum <= '0;
        end else if (adv && r_b_valid) begin
            r_sum <= r_b_last ? '0 : n_sum;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_b_valid && r_b_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_b_valid && r_b_last) begin
            r_out_score <= n_sum;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_focus_score = r_out_score;

    // Checks.
    `ASSERT_ALWAYS(a_col_in_window, i_clk, i_rst_n, r_col <= width_last, "column past row end")
    `ASSERT_NEXT(a_score_held, i_clk, i_rst_n, r_out_valid && i_stall,
                 r_out_valid && $stable(r_out_score), "stalled score lost or changed")
    `ASSERT_ALWAYS(a_score_from_last, i_clk, i_rst_n,
                   $rose(r_out_valid) |-> $past(r_b_valid && r_b_last), "score without window end")

endmodule

>>> sim/vollath_f4_focus_measure_test.sv
`timescale 1ns / 1ps

module vollath_f4_focus_measure_test;
    import vf4_pkg::*;

    // Block geometry as instantiated, and the settings it wakes up with.
    localparam int MAX_W = 32;
    localparam int MAX_H = 512;
    localparam logic [CFG_WIDTH_W-1:0]  DEFAULT_WIDTH  = 6'd16;
    localparam logic [CFG_HEIGHT_W-1:0] DEFAULT_HEIGHT = 10'd480;

    // Register indexes that map to nothing.
    localparam logic [CFG_INDEX_W-1:0] IDX_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] IDX_UNMAPPED_HI = 2'd3;

    // Cycles to let the pipeline empty before a register write, and at the end.
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    // Cycles without any beat on any channel before the run is abandoned.
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_PIXELS  = 16;

    typedef enum logic {ROW_CFG, ROW_PIXEL} t_row_kind;
    typedef enum logic [1:0] {PACE_FULL, PACE_SENDER_IDLE, PACE_SINK_STALL, PACE_BOTH} t_pace;

    typedef struct {
        t_row_kind                kind;
        logic [CFG_INDEX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]    value;
        bit                       typed;
        t_score                   score;
    } t_plan_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    t_pixel                  i_pixel;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    t_score                  o_focus_score;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_INDEX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    vollath_f4_focus_measure #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel       (i_pixel),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_focus_score (o_focus_score),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Directed windows: extremes, degenerate sizes, masked register bits and
    // writes to unmapped indexes in the middle of a window.
    localparam int PLAN_LEN = 29;
    t_plan_row directed_plan [PLAN_LEN] = '{
        '{ROW_CFG,   CFG_IDX_WIDTH,   16'd2,     1'b0, 0},
        '{ROW_CFG,   CFG_IDX_HEIGHT,  16'd2,     1'b0, 0},
        '{ROW_PIXEL, '0,              16'd255,   1'b0, 0},
        '{ROW_PIXEL, '0,              16'd255,   1'b0, 0},
        '{ROW_PIXEL, '0,              16'd255,   1'b0, 0},
        '{ROW_PIXEL, '0,              16'd255,   1'b1, 130050},
        '{ROW_CFG,   CFG_IDX_HEIGHT,  16'd1,     1'b0, 0},
        '{ROW_PIXEL, '0,              16'd0,     1'b0, 0},
        '{ROW_PIXEL, '0,              16'd255,   1'b1, 0},
        '{ROW_CFG,   CFG_IDX_WIDTH,   16'd1,     1'b0, 0},
        '{ROW_CFG,   CFG_IDX_HEIGHT,  16'd3,     1'b0, 0},
        '{ROW_PIXEL, '0,              16'd255,   1'b0, 0},
        '{ROW_PIXEL, '0,              16'd0,     1'b0, 0},
        '{ROW_PIXEL, '0,              16'd255,   1'b1, -65025},
        '{ROW_CFG,   CFG_IDX_HEIGHT,  16'd0,     1'b0, 0},
        '{ROW_PIXEL, '0,              16'd200,   1'b1, 0},
        '{ROW_CFG,   CFG_IDX_WIDTH,   16'hFFC3,  1'b0, 0},
        '{ROW_CFG,   CFG_IDX_HEIGHT,  16'hFC02,  1'b0, 0},
        '{ROW_PIXEL, '0,              16'd1,     1'b0, 0},
        '{ROW_PIXEL, '0,              16'd2,     1'b0, 0},
        '{ROW_CFG,   IDX_UNMAPPED_LO, 16'hFFFF,  1'b0, 0},
        '{ROW_CFG,   IDX_UNMAPPED_HI, 16'hFFFF,  1'b0, 0},
        '{ROW_PIXEL, '0,              16'd3,     1'b0, 0},
        '{ROW_PIXEL, '0,              16'd4,     1'b0, 0},
        '{ROW_PIXEL, '0,              16'd5,     1'b0, 0},
        '{ROW_PIXEL, '0,              16'd6,     1'b1, 32},
        '{ROW_CFG,   CFG_IDX_WIDTH,   16'd0,     1'b0, 0},
        '{ROW_PIXEL, '0,              16'd255,   1'b0, 0},
        '{ROW_PIXEL, '0,              16'd255,   1'b1, 65025}
    };

    // Predicted block state.
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    t_pixel                  above_row [MAX_W];
    t_pixel                  above2_row [MAX_W];
    int unsigned             col_pos;
    int unsigned             row_pos;
    logic [SCORE_W-1:0]      lag1_acc;
    logic [SCORE_W-1:0]      lag2_acc;

    t_score expected_scores [$];
    t_score next_score;
    int     mismatch_count = 0;
    int     quiet_cycles = 0;
    int     send_idle_pct = 0;
    int     sink_stall_pct = 0;

    function automatic int unsigned eff_dim(input int unsigned v, input int unsigned bound);
        if (v == 0) return 1;
        if (v > bound) return bound;
        return v;
    endfunction

    function automatic void clear_window();
        col_pos  = 0;
        row_pos  = 0;
        lag1_acc = '0;
        lag2_acc = '0;
    endfunction

    function automatic void reset_predictor();
        width_reg  = DEFAULT_WIDTH;
        height_reg = DEFAULT_HEIGHT;
        for (int i = 0; i < MAX_W; i++) begin
            above_row[i]  = '0;
            above2_row[i] = '0;
        end
        clear_window();
    endfunction

    function automatic void apply_register_write(input logic [CFG_INDEX_W-1:0] idx,
                                                 input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_IDX_WIDTH) begin
            width_reg = data[CFG_WIDTH_W-1:0];
            clear_window();
        end else if (idx == CFG_IDX_HEIGHT) begin
            height_reg = data[CFG_HEIGHT_W-1:0];
            clear_window();
        end
    endfunction

    // Folds one pixel into the lag sums; returns 1 when it closes a window.
    function automatic bit accumulate_pixel(input t_pixel px, output t_score score);
        int unsigned w;
        int unsigned h;
        w = eff_dim(width_reg, MAX_W);
        h = eff_dim(height_reg, MAX_H);
        score = '0;
        if (row_pos >= 1) lag1_acc = lag1_acc + px * above_row[col_pos];
        if (row_pos >= 2) lag2_acc = lag2_acc + px * above2_row[col_pos];
        above2_row[col_pos] = above_row[col_pos];
        above_row[col_pos]  = px;
        if (col_pos + 1 < w) begin
            col_pos++;
            return 1'b0;
        end
        col_pos = 0;
        if (row_pos + 1 < h) begin
            row_pos++;
            return 1'b0;
        end
        score = t_score'(lag1_acc - lag2_acc);
        clear_window();
        return 1'b1;
    endfunction

    function automatic t_pixel random_pixel();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 8'd0;
        if (pick == 1) return 8'd255;
        return t_pixel'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned random_width();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        case (pick)
            0: return 0;
            1: return 1;
            2: return MAX_W;
            3: return 63;
            4: return $urandom_range(MAX_W + 1, 63);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic int unsigned random_height();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return 0;
            1: return 1;
            2: return 2;
            default: return $urandom_range(2, 6);
        endcase
    endfunction

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_FULL: begin
                send_idle_pct  = 0;
                sink_stall_pct = 0;
            end
            PACE_SENDER_IDLE: begin
                send_idle_pct  = 87;
                sink_stall_pct = 0;
            end
            PACE_SINK_STALL: begin
                send_idle_pct  = 0;
                sink_stall_pct = 87;
            end
            default: begin
                send_idle_pct  = 22;
                sink_stall_pct = 22;
            end
        endcase
    endtask

    // Sends one pixel beat and records the score it is predicted to cause.
    task automatic push_pixel(input t_pixel px, input bit typed, input t_score typed_score);
        t_score score;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            i_pixel = t_pixel'($urandom);
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_pixel = px;
        do @(posedge i_clk); while (o_stall);
        if (accumulate_pixel(px, score))
            expected_scores.insert(expected_scores.size(), typed ? typed_score : score);
    endtask

    // Holds the pixel channel quiet until every predicted score has been seen.
    task automatic wait_idle(input int settle);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_scores.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_idle(SETTLE_CYCLES);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register_write(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Sends whole windows of random pixels under the current settings.
    task automatic push_windows(input int unsigned windows, input int unsigned extra,
                                input int unsigned pause_at);
        int unsigned total;
        total = windows * eff_dim(width_reg, MAX_W) * eff_dim(height_reg, MAX_H) + extra;
        for (int unsigned n = 0; n < total; n++) begin
            if (n == pause_at) wait_idle(0);
            push_pixel(random_pixel(), 1'b0, '0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    // Score checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_scores.size() == 0) begin
                $error("focus_score: expected none, actual %0d", o_focus_score);
                mismatch_count++;
            end else begin
                next_score = expected_scores.pop_front();
                if (o_focus_score !== next_score) begin
                    $error("focus_score: expected %0d, actual %0d", next_score, o_focus_score);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat on any channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int unsigned windows;
        int unsigned size;
        int unsigned extra;
        int unsigned pause_at;
        t_pace       pace;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_pixel     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_IDX_WIDTH;
        i_cfg_data  = '0;
        reset_predictor();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // One two-row window at the power-up width checks the width reset value.
        set_pace(PACE_FULL);
        write_reg(CFG_IDX_HEIGHT, 16'd2);
        push_windows(1, 0, '1);

        // Directed table.
        for (int r = 0; r < PLAN_LEN; r++) begin
            if (directed_plan[r].kind == ROW_CFG)
                write_reg(directed_plan[r].index, directed_plan[r].value);
            else
                push_pixel(directed_plan[r].value[PIXEL_W-1:0], directed_plan[r].typed,
                           directed_plan[r].score);
        end

        // Random phases: new settings, pacing and content each time, with the
        // odd partial window left behind for the next register write to cut off.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            pace = t_pace'(p % 4);
            set_pace(pace);
            write_reg(CFG_IDX_WIDTH, {10'($urandom), 6'(random_width())});
            write_reg(CFG_IDX_HEIGHT, {6'($urandom), 10'(random_height())});
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? IDX_UNMAPPED_LO : IDX_UNMAPPED_HI,
                          CFG_DATA_W'($urandom));
            size = eff_dim(width_reg, MAX_W) * eff_dim(height_reg, MAX_H);
            windows = (PHASE_PIXELS + size - 1) / size;
            extra = ($urandom_range(0, 2) == 0) ? $urandom_range(0, size - 1) : 0;
            // Odd phases hold the sender back midway until all scores are in.
            pause_at = (p % 2 == 1) ? (windows * size) / 2 : '1;
            push_windows(windows, extra, pause_at);
        end

        // Widest window, reached through saturation of the width register.
        set_pace(PACE_FULL);
        write_reg(CFG_IDX_WIDTH, 16'd63);
        write_reg(CFG_IDX_HEIGHT, 16'd2);
        push_windows(1, 0, '1);

        wait_idle(TAIL_CYCLES);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
